FILE: sv/trr_pkg.sv
// Shared types and constants for the trace ring recorder.
// Holds the beat structs, frame layout and configuration register codes.
// No dependencies.
`default_nettype none

package trr_pkg;

	// Default sizing of the ring and of one read burst.
	localparam int RING_DEPTH_DEF = 4096;
	localparam int MAX_READ_DEF   = 64;

	// Hash value that marks a zero-tick result.
	localparam logic [31:0] ZERO_TICK_HASH = 32'h005A_4E00;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_DISPATCH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_EXECUTE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_COMPLETE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_ERROR     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_ZERO_TICK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OK_STATUS    = 3'd5;

	// Item modes.
	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	// Input beat.
	typedef struct packed {
		logic        mode;
		logic [6:0]  read_count;
		logic [63:0] timestamp;
		logic [31:0] sig_num;
		logic [7:0]  signal_kind;
		logic [7:0]  signal_type;
		logic [7:0]  result_ticks;
		logic [31:0] run_hash;
		logic [7:0]  status;
		logic [7:0]  flags;
		logic [7:0]  tick_cost;
	} in_item_t;

	// Output beat.
	typedef struct packed {
		logic        frame_valid;
		logic        last;
		logic [63:0] out_timestamp;
		logic [31:0] out_sig_num;
		logic [31:0] out_hash;
		logic [7:0]  out_ticks;
		logic [7:0]  out_status;
		logic [7:0]  out_flags;
		logic [63:0] ops_low;
		logic [63:0] ops_high;
		logic [63:0] zero_tick_total;
	} out_item_t;

	// Current configuration register contents.
	typedef struct packed {
		logic [7:0] op_dispatch;
		logic [7:0] op_execute;
		logic [7:0] op_complete;
		logic [7:0] op_error;
		logic [7:0] op_zero_tick;
		logic [7:0] ok_status;
	} cfg_regs_t;

	// One stored frame, one memory word.
	typedef struct packed {
		logic [63:0] timestamp;
		logic [31:0] sig_num;
		logic [31:0] hash;
		logic [7:0]  flags;
		logic [7:0]  status;
		logic [7:0]  ticks;
		logic [63:0] ops_low;
		logic [63:0] ops_high;
	} frame_t;

endpackage

`default_nettype wire

FILE: sv/trr_cfg_regs.sv
// Configuration register file of the trace ring recorder.
// Depends on trr_pkg for the register codes and the cfg_regs_t struct.
`default_nettype none

module trr_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [trr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data,
	output trr_pkg::cfg_regs_t                 regs
);
	import trr_pkg::*;

	cfg_regs_t regs_q;

	// Writes are always taken; an unknown index is dropped.
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Register writes, reset to the default trace codes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.op_dispatch  <= 8'd1;
			regs_q.op_execute   <= 8'd2;
			regs_q.op_complete  <= 8'd3;
			regs_q.op_error     <= 8'd4;
			regs_q.op_zero_tick <= 8'd5;
			regs_q.ok_status    <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OP_DISPATCH:  regs_q.op_dispatch  <= cfg_data;
				CFG_OP_EXECUTE:   regs_q.op_execute   <= cfg_data;
				CFG_OP_COMPLETE:  regs_q.op_complete  <= cfg_data;
				CFG_OP_ERROR:     regs_q.op_error     <= cfg_data;
				CFG_OP_ZERO_TICK: regs_q.op_zero_tick <= cfg_data;
				CFG_OK_STATUS:    regs_q.ok_status    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/trr_frame_enc.sv
// Frame encoder: turns a record beat into the frame word stored in the ring.
// Depends on trr_pkg for the beat, frame and configuration types.
`default_nettype none

module trr_frame_enc (
	input  wire trr_pkg::in_item_t  item,
	input  wire trr_pkg::cfg_regs_t regs,
	output trr_pkg::frame_t         frame,
	output logic                    zero_tick
);
	import trr_pkg::*;

	logic       status_ok;
	logic [7:0] end_code;

	assign zero_tick = (item.result_ticks == 8'd0) && (item.run_hash == ZERO_TICK_HASH);
	assign status_ok = (item.status == regs.ok_status);
	assign end_code  = status_ok ? regs.op_complete : regs.op_error;

	// Normal frames carry the full op trace; zero-tick frames carry a marker.
	always_comb begin
		frame.timestamp = item.timestamp;
		frame.sig_num   = item.sig_num;
		if (zero_tick) begin
			frame.hash     = ZERO_TICK_HASH;
			frame.flags    = 8'd0;
			frame.status   = regs.ok_status;
			frame.ticks    = 8'd0;
			frame.ops_low  = {48'd0, item.signal_type, regs.op_zero_tick};
			frame.ops_high = 64'd0;
		end else begin
			frame.hash     = item.run_hash;
			frame.flags    = item.flags;
			frame.status   = item.status;
			frame.ticks    = item.tick_cost;
			frame.ops_low  = {end_code, item.run_hash, regs.op_execute,
				item.signal_kind, regs.op_dispatch};
			frame.ops_high = status_ok ? 64'd0 : {56'd0, item.status};
		end
	end

endmodule

`default_nettype wire

FILE: sv/trr_frame_mem.sv
// Frame memory of the trace ring: one write port, one read port,
// read data registered. Depends on trr_pkg for the frame_t word.
`default_nettype none

module trr_frame_mem #(
	parameter int DEPTH  = trr_pkg::RING_DEPTH_DEF,
	parameter int ADDR_W = $clog2(trr_pkg::RING_DEPTH_DEF)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire trr_pkg::frame_t   wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output trr_pkg::frame_t        rd_data
);
	import trr_pkg::*;

	frame_t mem_q [DEPTH];
	frame_t rd_data_q;

	assign rd_data = rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data register holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/trace_ring_recorder_top.sv
// Trace ring recorder top level: controller, pointers and output register.
// Depends on trr_pkg, trr_cfg_regs, trr_frame_enc and trr_frame_mem.
`default_nettype none

// The recorder keeps up to RING_DEPTH-1 execution frames in one synchronous
// memory and overwrites the oldest frame once the ring is full. A record beat
// (mode 0) writes one memory word; it returns nothing. A read beat (mode 1)
// returns up to read_count (capped at MAX_READ) of the oldest frames, one per
// cycle while the output is not stalled, through the single memory read port,
// the read stage and the output register; the final frame is marked with
// last. A read of an empty ring, or with a count of zero, returns one beat
// with frame_valid low and last high. A read beat holds the input until its
// last frame, or its empty beat, has moved into the read stage, and longer
// while the output is stalled; after that the next beat is taken while
// earlier frames still drain through the read and output registers. The
// memory is not cleared after reset; only written entries are ever read back.
module trace_ring_recorder_top #(
	parameter int RING_DEPTH = trr_pkg::RING_DEPTH_DEF,
	parameter int MAX_READ   = trr_pkg::MAX_READ_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire trr_pkg::in_item_t             in_item,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output trr_pkg::out_item_t                 out_item,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [trr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data
);
	import trr_pkg::*;

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = $clog2(MAX_READ + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_READ);

	cfg_regs_t regs;
	frame_t    enc_frame;
	logic      enc_zero_tick;
	frame_t    rd_frame;

	// Control state.
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] remain_q;
	logic             empty_q;
	logic [63:0]      ztc_q;

	// Read stage: a frame fetched from memory (or an empty beat) waiting for
	// the output register.
	logic        valid_s1;
	logic        last_s1;
	logic        frame_s1;
	logic [63:0] ztc_s1;

	// Output register.
	logic      out_valid_q;
	out_item_t out_q;

	logic             accept, rec_accept, rd_accept;
	logic             load_out, stage_free, issue_mem, issue_empty;
	logic             issue_last, ring_empty;
	logic [PTR_W-1:0] wp_next, rp_next;
	logic [CNT_W-1:0] want;

	trr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	trr_frame_enc u_enc (
		.item      (in_item),
		.regs      (regs),
		.frame     (enc_frame),
		.zero_tick (enc_zero_tick)
	);

	trr_frame_mem #(
		.DEPTH  (RING_DEPTH),
		.ADDR_W (PTR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (rec_accept),
		.wr_addr (wp_q),
		.wr_data (enc_frame),
		.rd_en   (issue_mem),
		.rd_addr (rp_q),
		.rd_data (rd_frame)
	);

	// Handshake and pointer arithmetic.
	assign in_ready   = (remain_q == '0) && !empty_q;
	assign accept     = in_valid && in_ready;
	assign rec_accept = accept && (in_item.mode == MODE_RECORD);
	assign rd_accept  = accept && (in_item.mode == MODE_READ);
	assign wp_next    = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
	assign rp_next    = (rp_q == LAST_SLOT) ? '0 : rp_q + 1'b1;
	assign ring_empty = (rp_q == wp_q);
	assign want       = (in_item.read_count > 7'(MAX_READ)) ? MAX_CNT
		: CNT_W'(in_item.read_count);

	// Read issue: the memory data register is reloaded only when the read
	// stage is empty or moves on into the output register this cycle.
	assign load_out    = valid_s1 && (!out_valid_q || out_ready);
	assign stage_free  = !valid_s1 || load_out;
	assign issue_mem   = (remain_q != '0) && stage_free;
	assign issue_empty = empty_q && stage_free;
	assign issue_last  = (remain_q == CNT_W'(1)) || (rp_next == wp_q);

	// Pointers, burst count and zero-tick counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			remain_q <= '0;
			empty_q  <= 1'b0;
			ztc_q    <= 64'd0;
		end else begin
			if (rec_accept) begin
				wp_q <= wp_next;
				if (wp_next == rp_q) begin
					rp_q <= rp_next;
				end
				if (enc_zero_tick) begin
					ztc_q <= ztc_q + 64'd1;
				end
			end
			if (rd_accept) begin
				if ((want == '0) || ring_empty) begin
					empty_q <= 1'b1;
				end else begin
					remain_q <= want;
				end
			end
			if (issue_mem) begin
				rp_q     <= rp_next;
				remain_q <= issue_last ? '0 : remain_q - 1'b1;
			end
			if (issue_empty) begin
				empty_q <= 1'b0;
			end
		end
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue_mem || issue_empty) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read stage payload.
	always_ff @(posedge clk) begin
		if (issue_mem || issue_empty) begin
			last_s1  <= issue_empty || issue_last;
			frame_s1 <= issue_mem;
			ztc_s1   <= ztc_q;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; an empty beat carries zero frame fields.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.frame_valid     <= frame_s1;
			out_q.last            <= last_s1;
			out_q.zero_tick_total <= ztc_s1;
			if (frame_s1) begin
				out_q.out_timestamp <= rd_frame.timestamp;
				out_q.out_sig_num   <= rd_frame.sig_num;
				out_q.out_hash      <= rd_frame.hash;
				out_q.out_ticks     <= rd_frame.ticks;
				out_q.out_status    <= rd_frame.status;
				out_q.out_flags     <= rd_frame.flags;
				out_q.ops_low       <= rd_frame.ops_low;
				out_q.ops_high      <= rd_frame.ops_high;
			end else begin
				out_q.out_timestamp <= 64'd0;
				out_q.out_sig_num   <= 32'd0;
				out_q.out_hash      <= 32'd0;
				out_q.out_ticks     <= 8'd0;
				out_q.out_status    <= 8'd0;
				out_q.out_flags     <= 8'd0;
				out_q.ops_low       <= 64'd0;
				out_q.ops_high      <= 64'd0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// A memory read never starts on an empty ring.
	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		issue_mem |-> !ring_empty)
		else $error("frame read issued on an empty ring");

	// Record writes and frame reads never share a cycle.
	a_no_wr_rd_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rec_accept && issue_mem))
		else $error("memory write and read in the same cycle");

	// An empty beat is always the final beat of its read.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.frame_valid |-> out_item.last && out_item.ops_low == 64'd0)
		else $error("empty read beat not marked last or not cleared");

	// The read stage is reloaded only once its previous content moved on.
	a_stage_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !(!out_valid_q || out_ready) |-> !issue_mem && !issue_empty)
		else $error("read stage overwritten while stalled");

endmodule

`default_nettype wire
